### src/whp_pkg.sv
// Shared types and constants for the WAVE header parser.
package whp_pkg;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic        is_stereo;
        logic [32:0] data_start;
        logic [33:0] data_stop;
    } out_item_t;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE = 3'd2;
    localparam logic [2:0] ST_NO_FMT   = 3'd3;
    localparam logic [2:0] ST_NOT_PCM  = 3'd4;
    localparam logic [2:0] ST_NO_DATA  = 3'd5;
    localparam logic [2:0] ST_LAYOUT   = 3'd6;

    // Chunk ids as they sit in the little-endian shift register
    localparam logic [31:0] SIG_RIFF = 32'h4646_4952;
    localparam logic [31:0] SIG_WAVE = 32'h4556_4157;
    localparam logic [31:0] SIG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] SIG_DATA = 32'h6174_6164;

    localparam logic [32:0] OFFSET_STOP = 33'h1_FFFF_FFFF;
    localparam logic [33:0] FIRST_CHUNK = 34'd12;

    localparam int QUEUE_DEPTH = 4;

endpackage

### src/whp_front.sv
// Input side: accepts header bytes and queues them for the parser.
module whp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  whp_pkg::in_item_t in_item,
    output logic              q_valid,
    output whp_pkg::in_item_t q_item,
    input  logic              q_pop
);

    localparam int QD  = whp_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);

    whp_pkg::in_item_t mem_reg [QD];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           push;

    assign in_stall = (count_reg == (QAW+1)'(QD));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QD))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a request");

endmodule

### src/whp_parse.sv
// Parser: walks RIFF chunks one byte per cycle unless stalled, holds results.
module whp_parse
#(
    parameter int WINDOW_BYTES = 2048
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [10:0]        cfg_data,
    input  logic               q_valid,
    input  whp_pkg::in_item_t  q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output whp_pkg::out_item_t out_item
);

    localparam int LIMIT_RAW = WINDOW_BYTES - 256;
    localparam logic [10:0] LIMIT_RESET = (LIMIT_RAW > 2047) ? 11'd2047 : 11'(LIMIT_RAW);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_HDR       = 3'd1;
    localparam logic [2:0] PH_FMT_SEEK  = 3'd2;
    localparam logic [2:0] PH_FMT_BODY  = 3'd3;
    localparam logic [2:0] PH_DATA_SEEK = 3'd4;
    localparam logic [2:0] PH_DATA_BODY = 3'd5;
    localparam logic [2:0] PH_DONE      = 3'd6;

    logic [10:0] search_limit_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [32:0] byte_offset_reg, byte_offset_next;
    logic [33:0] chunk_start_reg, chunk_start_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [31:0] chunk_size_reg, chunk_size_next;
    logic [15:0] format_tag_reg, format_tag_next;
    logic [15:0] channel_count_reg, channel_count_next;
    logic [31:0] held_rate_reg, held_rate_next;
    logic [15:0] held_bits_reg, held_bits_next;
    logic        out_valid_reg;
    whp_pkg::out_item_t out_item_reg;

    logic        active;
    logic [2:0]  ph;
    logic [32:0] pos;
    logic [31:0] base_shift, sh;
    logic [33:0] cs;
    logic [33:0] rel;
    logic        before_chunk;
    logic        over_limit;
    logic [32:0] start_off;
    logic        stereo;
    logic        res_valid;
    whp_pkg::out_item_t res;

    assign q_pop     = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_offset_next   = byte_offset_reg;
        chunk_start_next   = chunk_start_reg;
        field_shift_next   = field_shift_reg;
        chunk_size_next    = chunk_size_reg;
        format_tag_next    = format_tag_reg;
        channel_count_next = channel_count_reg;
        held_rate_next     = held_rate_reg;
        held_bits_next     = held_bits_reg;
        res_valid          = 1'b0;
        res                = '0;

        active = q_item.first || (phase_reg != PH_IDLE && phase_reg != PH_DONE);
        ph     = q_item.first ? PH_HDR : phase_reg;
        pos    = q_item.first ? '0 : byte_offset_reg;
        cs     = q_item.first ? whp_pkg::FIRST_CHUNK : chunk_start_reg;
        base_shift   = q_item.first ? '0 : field_shift_reg;
        sh           = {q_item.header_byte, base_shift[31:8]};
        rel          = {1'b0, pos} - cs;
        before_chunk = ({1'b0, pos} < cs);
        over_limit   = (cs > {23'd0, search_limit_reg});
        start_off    = cs[32:0] + 33'd8;
        stereo       = (channel_count_reg == 16'd2);

        if (q_pop)
        begin
            // restart: drop everything from the previous parse
            if (q_item.first)
            begin
                phase_next         = PH_HDR;
                byte_offset_next   = '0;
                chunk_start_next   = whp_pkg::FIRST_CHUNK;
                field_shift_next   = '0;
                chunk_size_next    = '0;
                format_tag_next    = '0;
                channel_count_next = '0;
                held_rate_next     = '0;
                held_bits_next     = '0;
            end
            if (active && pos != whp_pkg::OFFSET_STOP)
            begin
                byte_offset_next = pos + 33'd1;
                field_shift_next = sh;
                case (ph)
                    PH_HDR:
                    begin
                        if (pos == 33'd3 && sh != whp_pkg::SIG_RIFF)
                        begin
                            res_valid  = 1'b1;
                            res.status = whp_pkg::ST_BAD_RIFF;
                        end
                        else if (pos == 33'd11)
                        begin
                            if (sh != whp_pkg::SIG_WAVE)
                            begin
                                res_valid  = 1'b1;
                                res.status = whp_pkg::ST_BAD_WAVE;
                            end
                            else
                            begin
                                phase_next = PH_FMT_SEEK;
                            end
                        end
                    end
                    PH_FMT_SEEK, PH_DATA_SEEK:
                    begin
                        if (!before_chunk && rel == 34'd3)
                        begin
                            if (ph == PH_FMT_SEEK && sh == whp_pkg::SIG_FMT)
                            begin
                                phase_next = PH_FMT_BODY;
                            end
                            else if (ph == PH_DATA_SEEK && sh == whp_pkg::SIG_DATA)
                            begin
                                phase_next = PH_DATA_BODY;
                            end
                            else if (over_limit)
                            begin
                                res_valid  = 1'b1;
                                res.status = (ph == PH_FMT_SEEK) ? whp_pkg::ST_NO_FMT
                                                                 : whp_pkg::ST_NO_DATA;
                            end
                        end
                        else if (!before_chunk && rel == 34'd7)
                        begin
                            // skip the unwanted chunk: header plus body
                            chunk_start_next = cs + {2'b00, sh} + 34'd8;
                        end
                    end
                    PH_FMT_BODY:
                    begin
                        if (!before_chunk && rel == 34'd7)
                        begin
                            chunk_size_next = sh;
                        end
                        else if (!before_chunk && rel == 34'd9)
                        begin
                            format_tag_next = sh[31:16];
                            if (sh[31:16] != 16'd1)
                            begin
                                res_valid  = 1'b1;
                                res.status = whp_pkg::ST_NOT_PCM;
                            end
                        end
                        else if (!before_chunk && rel == 34'd11)
                        begin
                            channel_count_next = sh[31:16];
                        end
                        else if (!before_chunk && rel == 34'd15)
                        begin
                            held_rate_next = sh;
                        end
                        else if (!before_chunk && rel == 34'd23)
                        begin
                            held_bits_next = sh[31:16];
                            if (chunk_size_reg < 32'd16)
                            begin
                                res_valid  = 1'b1;
                                res.status = whp_pkg::ST_LAYOUT;
                            end
                            else
                            begin
                                chunk_start_next = cs + {2'b00, chunk_size_reg} + 34'd8;
                                phase_next       = PH_DATA_SEEK;
                            end
                        end
                    end
                    PH_DATA_BODY:
                    begin
                        if (!before_chunk && rel == 34'd7)
                        begin
                            res_valid       = 1'b1;
                            res.status      = (stereo && held_bits_reg == 16'd16)
                                              ? whp_pkg::ST_OK : whp_pkg::ST_LAYOUT;
                            res.rate_hz     = held_rate_reg;
                            res.sample_bits = held_bits_reg;
                            res.is_stereo   = stereo;
                            res.data_start  = start_off;
                            res.data_stop   = {1'b0, start_off} + {2'b00, sh};
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (res_valid)
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_limit_reg  <= LIMIT_RESET;
            phase_reg         <= PH_IDLE;
            byte_offset_reg   <= '0;
            chunk_start_reg   <= whp_pkg::FIRST_CHUNK;
            field_shift_reg   <= '0;
            chunk_size_reg    <= '0;
            format_tag_reg    <= '0;
            channel_count_reg <= '0;
            held_rate_reg     <= '0;
            held_bits_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                search_limit_reg <= cfg_data;
            end
            phase_reg         <= phase_next;
            byte_offset_reg   <= byte_offset_next;
            chunk_start_reg   <= chunk_start_next;
            field_shift_reg   <= field_shift_next;
            chunk_size_reg    <= chunk_size_next;
            format_tag_reg    <= format_tag_next;
            channel_count_reg <= channel_count_next;
            held_rate_reg     <= held_rate_next;
            held_bits_reg     <= held_bits_next;
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_item_reg <= res;
        end
    end

    a_result_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> phase_reg == PH_DONE)
        else $error("parse continued after its result");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> byte_offset_reg == '0)
        else $error("bytes counted before first byte");

    a_body_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FMT_BODY || phase_reg == PH_DATA_BODY)
        |-> chunk_start_reg < {1'b0, byte_offset_reg})
        else $error("chunk body entered before its start");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !res_valid)
        else $error("held result overwritten");

endmodule

### src/wav_header_parser.sv
// Top level of the RIFF/WAVE header parser.
// Header bytes enter one per request from offset zero up (first marks offset zero and
// restarts the parse); each parse gives at most one result with a status, the fmt
// fields and the data chunk bounds. The block sustains one byte per cycle while no result
// is held by the receiver: every byte is a single update of the parser's counters and
// shift register. A byte passes through a four-entry input queue: it is written into the
// queue memory when accepted and leaves it from there; its result, if any, lands in the
// output register at the edge where the byte leaves the queue, so a result passes through
// the queue memory and the output register before it is offered. A result held by the
// receiver stops the queue, and the input stalls once four bytes wait. The search limit
// register resets to WINDOW_BYTES - 256 (at most 2047) and may be written whenever no
// parse is in flight; no clearing pass follows reset.
module wav_header_parser
#(
    parameter int WINDOW_BYTES = 2048
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  whp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output whp_pkg::out_item_t out_item
);

    logic              q_valid;
    logic              q_pop;
    whp_pkg::in_item_t q_item;

    assign cfg_ready = 1'b1;

    whp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    whp_parse #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

### tb/wav_header_parser_test.sv
// Self-checking testbench for the RIFF/WAVE header parser: byte streams in, parse results checked.
module wav_header_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] P_WAITING   = 3'd0;
    localparam logic [2:0] P_HEADER    = 3'd1;
    localparam logic [2:0] P_SEEK_FMT  = 3'd2;
    localparam logic [2:0] P_IN_FMT    = 3'd3;
    localparam logic [2:0] P_SEEK_DATA = 3'd4;
    localparam logic [2:0] P_IN_DATA   = 3'd5;
    localparam logic [2:0] P_FINISHED  = 3'd6;

    localparam logic [10:0] LIMIT_AT_RESET = 11'd1792;
    localparam logic [10:0] LIMIT_TOP      = 11'd2047;
    localparam logic [15:0] TAG_PCM        = 16'd1;
    localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
    localparam logic [31:0] JUNK_ID        = 32'h4B4E_554A;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          RANDOM_BYTES   = 700;
    localparam int          MAX_REPORTS    = 10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [10:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    whp_pkg::in_item_t   in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    whp_pkg::out_item_t  out_item;

    wav_header_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Parser mirror
    logic [2:0]   p_phase;
    logic [10:0]  p_limit;
    logic [32:0]  p_pos;
    logic [33:0]  p_chunk;
    logic [31:0]  p_shift;
    logic [31:0]  p_size;
    logic [15:0]  p_tag;
    logic [15:0]  p_chans;
    logic [31:0]  p_rate;
    logic [15:0]  p_bits;

    whp_pkg::out_item_t due_results[$];
    logic [7:0]         file_q[$];
    int                 bad_count = 0;
    int                 bytes_parsed = 0;
    int                 parse_results = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 hold_left = 0;

    function automatic void restart_parse();
        p_pos   = '0;
        p_chunk = whp_pkg::FIRST_CHUNK;
        p_shift = '0;
        p_size  = '0;
        p_tag   = '0;
        p_chans = '0;
        p_rate  = '0;
        p_bits  = '0;
    endfunction

    function automatic whp_pkg::out_item_t end_with(input logic [2:0] st);
        whp_pkg::out_item_t r;
        r = '0;
        r.status = st;
        p_phase = P_FINISHED;
        return r;
    endfunction

    // Advance the mirror by one byte; returns 1 when the byte decides the parse.
    function automatic bit parse_byte(input logic [7:0] b, input logic restart,
                                      output whp_pkg::out_item_t res,
                                      output bit used);
        logic [32:0] pos;
        logic [33:0] rel;
        logic [33:0] start;
        logic        want_fmt;
        res = '0;
        used = 1'b0;
        if (restart)
        begin
            restart_parse();
            p_phase = P_HEADER;
        end
        else if (p_phase == P_WAITING || p_phase == P_FINISHED)
            return 1'b0;
        if (p_pos >= whp_pkg::OFFSET_STOP)
            return 1'b0;
        used = 1'b1;
        pos = p_pos;
        p_pos = p_pos + 33'd1;
        p_shift = {b, p_shift[31:8]};

        if (p_phase == P_HEADER)
        begin
            if (pos == 33'd3 && p_shift != whp_pkg::SIG_RIFF)
            begin
                res = end_with(whp_pkg::ST_BAD_RIFF);
                return 1'b1;
            end
            if (pos == 33'd11)
            begin
                if (p_shift != whp_pkg::SIG_WAVE)
                begin
                    res = end_with(whp_pkg::ST_BAD_WAVE);
                    return 1'b1;
                end
                p_phase = P_SEEK_FMT;
            end
            return 1'b0;
        end
        if ({1'b0, pos} < p_chunk)
            return 1'b0;
        rel = {1'b0, pos} - p_chunk;

        case (p_phase)
            P_SEEK_FMT, P_SEEK_DATA:
            begin
                want_fmt = (p_phase == P_SEEK_FMT);
                if (rel == 34'd3)
                begin
                    if (p_shift == (want_fmt ? whp_pkg::SIG_FMT : whp_pkg::SIG_DATA))
                    begin
                        if (want_fmt)
                            p_phase = P_IN_FMT;
                        else
                            p_phase = P_IN_DATA;
                    end
                    else if (p_chunk > {23'd0, p_limit})
                    begin
                        res = end_with(want_fmt ? whp_pkg::ST_NO_FMT
                                                : whp_pkg::ST_NO_DATA);
                        return 1'b1;
                    end
                end
                else if (rel == 34'd7)
                    p_chunk = p_chunk + {2'b00, p_shift} + 34'd8;
            end
            P_IN_FMT:
            begin
                if (rel == 34'd7)
                    p_size = p_shift;
                else if (rel == 34'd9)
                begin
                    p_tag = p_shift[31:16];
                    if (p_tag != TAG_PCM)
                    begin
                        res = end_with(whp_pkg::ST_NOT_PCM);
                        return 1'b1;
                    end
                end
                else if (rel == 34'd11)
                    p_chans = p_shift[31:16];
                else if (rel == 34'd15)
                    p_rate = p_shift;
                else if (rel == 34'd23)
                begin
                    p_bits = p_shift[31:16];
                    // a short fmt chunk would point back into bytes already gone
                    if (p_size < FMT_MIN_SIZE)
                    begin
                        res = end_with(whp_pkg::ST_LAYOUT);
                        return 1'b1;
                    end
                    p_chunk = p_chunk + {2'b00, p_size} + 34'd8;
                    p_phase = P_SEEK_DATA;
                end
            end
            P_IN_DATA:
            begin
                if (rel == 34'd7)
                begin
                    start = p_chunk + 34'd8;
                    res.status = (p_chans == 16'd2 && p_bits == 16'd16)
                                 ? whp_pkg::ST_OK : whp_pkg::ST_LAYOUT;
                    res.rate_hz = p_rate;
                    res.sample_bits = p_bits;
                    res.is_stereo = (p_chans == 16'd2);
                    res.data_start = start[32:0];
                    res.data_stop = start + {2'b00, p_shift};
                    p_phase = P_FINISHED;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Receiver: a long hold-off takes precedence over random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_result
        whp_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d rate %h bits %h stereo %b",
                             out_item.status, out_item.rate_hz, out_item.sample_bits,
                             out_item.is_stereo);
            end
            else
            begin
                want = due_results.pop_front();
                if (out_item.status !== want.status || out_item.rate_hz !== want.rate_hz
                    || out_item.sample_bits !== want.sample_bits
                    || out_item.is_stereo !== want.is_stereo
                    || out_item.data_start !== want.data_start
                    || out_item.data_stop !== want.data_stop)
                begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                    begin
                        $display("mismatch exp: st %0d rate %h bits %h st2 %b start %h stop %h",
                                 want.status, want.rate_hz, want.sample_bits,
                                 want.is_stereo, want.data_start, want.data_stop);
                        $display("         got: st %0d rate %h bits %h st2 %b start %h stop %h",
                                 out_item.status, out_item.rate_hz, out_item.sample_bits,
                                 out_item.is_stereo, out_item.data_start, out_item.data_stop);
                    end
                end
            end
        end
    end

    task automatic set_traffic(input int mode);
        case (mode)
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            3: begin idle_pct = 36; stall_pct = 36; end
            default: begin idle_pct = 0; stall_pct = 0; end
        endcase
    endtask

    // Offer one byte, hold it until taken, then predict its outcome
    task automatic send_byte(input logic [7:0] b, input logic restart);
        whp_pkg::out_item_t res;
        bit                 used;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_item <= '{header_byte: b, first: restart};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (parse_byte(b, restart, res, used))
        begin
            due_results.push_back(res);
            parse_results++;
        end
        if (used)
            bytes_parsed++;
    endtask

    task automatic send_file();
        foreach (file_q[i])
            send_byte(file_q[i], i == 0);
    endtask

    // Close any open parse, then wait until the block has nothing left in flight
    task automatic settle();
        if (p_phase != P_WAITING && p_phase != P_FINISHED)
        begin
            send_byte(8'h00, 1'b1);
            repeat (3) send_byte(8'h00, 1'b0);
        end
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [10:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        p_limit = value;
    endtask

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_q.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_half(input logic [15:0] h);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
    endfunction

    function automatic void put_filler(input int unsigned n);
        repeat (n) file_q.push_back(8'($urandom));
    endfunction

    function automatic void put_preamble();
        file_q.delete();
        put_word(whp_pkg::SIG_RIFF);
        put_word($urandom);
        put_word(whp_pkg::SIG_WAVE);
    endfunction

    function automatic void put_chunk(input logic [31:0] id, input int unsigned size);
        put_word(id);
        put_word(size);
        put_filler(size);
    endfunction

    function automatic void put_fmt(input logic [31:0] size, input logic [15:0] tag,
                                    input logic [15:0] chans, input logic [31:0] rate,
                                    input logic [15:0] bits);
        put_word(whp_pkg::SIG_FMT);
        put_word(size);
        put_half(tag);
        put_half(chans);
        put_word(rate);
        put_word($urandom);
        put_half(16'($urandom));
        put_half(bits);
        if (size > FMT_MIN_SIZE)
            put_filler(size - FMT_MIN_SIZE);
    endfunction

    task automatic send_wave(input logic [31:0] fmt_size, input logic [15:0] tag,
                             input logic [15:0] chans, input logic [31:0] rate,
                             input logic [15:0] bits, input logic [31:0] data_size);
        put_preamble();
        put_fmt(fmt_size, tag, chans, rate, bits);
        put_word(whp_pkg::SIG_DATA);
        put_word(data_size);
        send_file();
    endtask

    task automatic test_header_errors();
        set_traffic(0);
        // nothing has started yet: drop these
        send_byte(8'h52, 1'b0);
        send_byte(8'hA5, 1'b0);
        file_q.delete();
        put_word(whp_pkg::SIG_RIFF ^ 32'h0100_0000);
        send_file();
        file_q.delete();
        put_word(32'hFFFF_FFFF);
        send_file();
        file_q.delete();
        put_word(whp_pkg::SIG_RIFF);
        put_word(32'h0);
        put_word(whp_pkg::SIG_WAVE ^ 32'h0000_0001);
        send_file();
        // restart in the middle of a chunk header
        put_preamble();
        put_word(whp_pkg::SIG_FMT);
        send_file();
        send_wave(32'd16, TAG_PCM, 16'd2, 32'd22050, 16'd16, 32'd100);
    endtask

    task automatic test_good_files();
        set_traffic(0);
        send_wave(32'd16, TAG_PCM, 16'd2, 32'd44100, 16'd16, 32'd0);
        send_wave(32'd18, TAG_PCM, 16'd2, 32'hFFFF_FFFF, 16'd16, 32'hFFFF_FFFF);
        // trailing bytes after the verdict are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_wave(32'd40, TAG_PCM, 16'd2, 32'd0, 16'd16, 32'h8000_0001);
    endtask

    task automatic test_fmt_fields();
        set_traffic(3);
        send_wave(32'd16, 16'd3, 16'd2, 32'd48000, 16'd16, 32'd8);
        send_wave(32'd16, 16'hFFFF, 16'd2, 32'd48000, 16'd16, 32'd8);
        send_wave(32'd16, 16'd0, 16'd2, 32'd48000, 16'd16, 32'd8);
        send_wave(32'd14, TAG_PCM, 16'd2, 32'd48000, 16'd16, 32'd8);
        send_wave(32'd0, TAG_PCM, 16'd2, 32'd48000, 16'd16, 32'd8);
        send_wave(32'd16, TAG_PCM, 16'd1, 32'd8000, 16'd16, 32'd64);
        send_wave(32'd16, TAG_PCM, 16'd2, 32'd8000, 16'd8, 32'd64);
        send_wave(32'd16, TAG_PCM, 16'hFFFF, 32'd96000, 16'hFFFF, 32'hFFFF_FFFE);
    endtask

    task automatic test_search_limit();
        settle();
        set_traffic(1);
        write_limit(11'd12);
        // junk at the limit is skipped, junk beyond it ends the search
        put_preamble();
        put_chunk(JUNK_ID, 4);
        put_word(JUNK_ID);
        put_word(32'd0);
        send_file();
        put_preamble();
        put_fmt(32'd16, TAG_PCM, 16'd2, 32'd44100, 16'd16);
        put_chunk(whp_pkg::SIG_FMT, 0);
        send_file();
        settle();
        write_limit(11'd0);
        send_wave(32'd16, TAG_PCM, 16'd2, 32'd44100, 16'd16, 32'd12);
        put_preamble();
        put_chunk(whp_pkg::SIG_DATA, 2);
        send_file();
        settle();
        write_limit(LIMIT_TOP);
        // ids of the other chunk kind are skipped as junk
        put_preamble();
        put_chunk(whp_pkg::SIG_DATA, 3);
        put_chunk(JUNK_ID, 0);
        put_fmt(32'd16, TAG_PCM, 16'd2, 32'd32000, 16'd16);
        put_chunk(whp_pkg::SIG_FMT, 1);
        put_word(whp_pkg::SIG_DATA);
        put_word($urandom);
        send_file();
    endtask

    task automatic test_backpressure();
        settle();
        set_traffic(0);
        hold_left = 400;
        // short failing headers give a verdict every four bytes
        repeat (24)
        begin
            file_q.delete();
            put_word(32'h0);
            send_file();
        end
    endtask

    task automatic put_junk(input logic [31:0] alt_id);
        logic [31:0]  id;
        int unsigned  size;
        id = ($urandom_range(3) == 0) ? alt_id : 32'($urandom);
        if ($urandom_range(19) == 0)
            size = $urandom_range(41, 300);
        else
            size = $urandom_range(0, 12);
        put_chunk(id, size);
    endtask

    task automatic send_random_file();
        int unsigned pick;
        int unsigned r;
        int unsigned cut;
        logic [31:0] fmt_size;
        logic [15:0] tag;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] data_size;
        pick = $urandom_range(99);
        file_q.delete();
        if (pick < 4)
        begin
            // noise with an occasional restart
            repeat ($urandom_range(1, 24))
                send_byte(8'($urandom), $urandom_range(15) == 0);
            return;
        end
        put_word(pick < 7 ? 32'($urandom) : whp_pkg::SIG_RIFF);
        put_word($urandom);
        put_word((pick >= 7 && pick < 10) ? 32'($urandom) : whp_pkg::SIG_WAVE);
        repeat ($urandom_range(0, 3) == 3 ? 2 : $urandom_range(0, 1))
            put_junk(whp_pkg::SIG_DATA);

        r = $urandom_range(99);
        fmt_size = (r < 80) ? 32'd16 : (r < 92) ? 32'($urandom_range(17, 40))
                                                : 32'($urandom_range(0, 15));
        tag = ($urandom_range(9) == 0) ? 16'($urandom) : TAG_PCM;
        r = $urandom_range(99);
        chans = (r < 75) ? 16'd2 : (r < 88) ? 16'd1 : 16'($urandom);
        case ($urandom_range(4))
            0: rate = 32'd8000;
            1: rate = 32'd44100;
            2: rate = 32'd48000;
            3: rate = 32'd96000;
            default: rate = $urandom;
        endcase
        r = $urandom_range(99);
        bits = (r < 75) ? 16'd16 : (r < 83) ? 16'd8 : (r < 91) ? 16'd24 : 16'($urandom);
        put_fmt(fmt_size, tag, chans, rate, bits);

        repeat ($urandom_range(0, 3) == 3 ? 2 : $urandom_range(0, 1))
            put_junk(whp_pkg::SIG_FMT);
        r = $urandom_range(9);
        data_size = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        put_word(whp_pkg::SIG_DATA);
        put_word(data_size);

        if (pick >= 90)
        begin
            // broken stream: cut it short, the next restart takes over
            cut = $urandom_range(1, file_q.size() - 1);
            file_q = file_q[0:cut-1];
        end
        send_file();
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_random();
        int          goal_bytes;
        int          goal_results;
        logic [10:0] limit;
        for (int seg = 0; seg < 4; seg++)
        begin
            settle();
            case (seg)
                0: limit = LIMIT_TOP;
                1: limit = 11'($urandom_range(13, 120));
                2: limit = 11'd0;
                default: limit = 11'($urandom_range(0, 2047));
            endcase
            write_limit(limit);
            set_traffic(seg);
            goal_bytes = bytes_parsed + RANDOM_BYTES / 4;
            goal_results = parse_results + 3;
            while (bytes_parsed < goal_bytes || parse_results < goal_results)
                send_random_file();
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        p_limit = LIMIT_AT_RESET;
        p_phase = P_WAITING;
        restart_parse();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_errors();
        test_good_files();
        test_fmt_fields();
        test_search_limit();
        test_backpressure();
        test_random();
        settle();
        if (bad_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
